>>> design/med3x3_pkg.sv
// shared types, constants and the nine-input median network of the 3x3 median filter
`default_nettype none

package med3x3_pkg;

   localparam int PIX_W        = 8;
   localparam int OUT_X_W      = 10;
   localparam int OUT_Y_W      = 12;
   localparam int CSR_ADDR_W   = 4;
   localparam int CSR_DATA_W   = 16;
   localparam int CSR_WIDTH_W  = 11;
   localparam int CSR_HEIGHT_W = 13;

   localparam int IMG_WIDTH_RST  = 640;
   localparam int IMG_HEIGHT_RST = 480;

   localparam logic [CSR_ADDR_W-1:0] CSR_IMAGE_WIDTH  = CSR_ADDR_W'(0);
   localparam logic [CSR_ADDR_W-1:0] CSR_IMAGE_HEIGHT = CSR_ADDR_W'(1);

   typedef logic [PIX_W-1:0] pix_type;
   typedef pix_type [8:0] win_type;

   // one column of the window: r0 is the upper row, r2 the newest row
   typedef struct packed {
      pix_type r0;
      pix_type r1;
      pix_type r2;
   } col_type;

   typedef struct packed {
      logic xm1;
      logic xm2;
      logic xe;
      logic ym1;
      logic ym2;
      logic ye;
   } pos_flags_type;

   function automatic win_type exch(win_type v, int i, int j);
      pix_type t;
      t = v[i];
      if (v[i] > v[j]) begin
         v[i] = v[j];
         v[j] = t;
      end
      return v;
   endfunction

   function automatic pix_type median9(win_type w);
      win_type v;
      v = w;
      v = exch(v, 1, 2); v = exch(v, 4, 5); v = exch(v, 7, 8);
      v = exch(v, 0, 1); v = exch(v, 3, 4); v = exch(v, 6, 7);
      v = exch(v, 1, 2); v = exch(v, 4, 5); v = exch(v, 7, 8);
      v = exch(v, 0, 3); v = exch(v, 5, 8); v = exch(v, 4, 7);
      v = exch(v, 3, 6); v = exch(v, 1, 4); v = exch(v, 2, 5);
      v = exch(v, 4, 7); v = exch(v, 4, 2); v = exch(v, 6, 4);
      v = exch(v, 4, 2);
      return v[4];
   endfunction

endpackage

`default_nettype wire

>>> design/med3x3_if.sv
// stream and register-write interfaces of the 3x3 median filter
`default_nettype none

interface med3x3_pix_if
   import med3x3_pkg::*;
();
   logic    valid;
   logic    ready;
   pix_type pixel;

   modport source (output valid, output pixel, input ready);
   modport sink   (input valid, input pixel, output ready);
endinterface

interface med3x3_res_if
   import med3x3_pkg::*;
();
   logic               valid;
   logic               ready;
   pix_type            median;
   logic [OUT_X_W-1:0] out_x;
   logic [OUT_Y_W-1:0] out_y;
   logic               last_of_run;
   logic               frame_done;

   modport source (output valid, output median, output out_x, output out_y,
                   output last_of_run, output frame_done, input ready);
   modport sink   (input valid, input median, input out_x, input out_y,
                   input last_of_run, input frame_done, output ready);
endinterface

interface med3x3_csr_if
   import med3x3_pkg::*;
();
   logic                  valid;
   logic                  ready;
   logic [CSR_ADDR_W-1:0] addr;
   logic [CSR_DATA_W-1:0] wdata;

   modport source (output valid, output addr, output wdata, input ready);
   modport sink   (input valid, input addr, input wdata, output ready);
endinterface

`default_nettype wire

>>> design/median3x3_stream_filter.sv
// 3x3 median filter over a raster pixel stream, with three row buffers
// a pixel passes the input stage, then the window stage; its results then go into the output register
// throughput: one pixel per cycle while the result side is ready; a pixel that completes two or four neighbourhoods
//   (row end, last row) holds the input until its results have been loaded, one result per cycle
// the single median network behind the output register sets the one-result-per-cycle rate while results are taken
// reset: counters and pipeline cleared, width 640 and height 480; row buffers keep their contents
`default_nettype none

module median3x3_stream_filter
   import med3x3_pkg::*;
#(
   parameter int MAX_WIDTH  = 1024,
   parameter int MAX_HEIGHT = 4096
) (
   input  logic         clock,
   input  logic         reset,
   med3x3_csr_if.sink   csr_if,
   med3x3_pix_if.sink   req_if,
   med3x3_res_if.source rsp_if
);

   localparam int XW  = $clog2(MAX_WIDTH);
   localparam int YW  = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
   localparam int WCW = (CSR_WIDTH_W > XW + 1) ? CSR_WIDTH_W : XW + 1;
   localparam int HCW = (CSR_HEIGHT_W > YW + 1) ? CSR_HEIGHT_W : YW + 1;
   localparam logic [XW-1:0] W_LAST_RST =
      XW'(((IMG_WIDTH_RST > MAX_WIDTH) ? MAX_WIDTH : IMG_WIDTH_RST) - 1);
   localparam logic [YW-1:0] H_LAST_RST =
      YW'(((IMG_HEIGHT_RST > MAX_HEIGHT) ? MAX_HEIGHT : IMG_HEIGHT_RST) - 1);

   // configuration
   logic           csr_fire, csr_hit;
   logic [WCW-1:0] w_wr;
   logic [HCW-1:0] h_wr;
   logic [XW-1:0]  w_last_wr, w_last_ff, w_last_in;
   logic [YW-1:0]  h_last_wr, h_last_ff, h_last_in;

   // position counters
   logic          req_fire;
   logic [XW-1:0] cx_ff, cx_in;
   logic [YW-1:0] cy_ff, cy_in;
   logic [1:0]    slot_ff, slot_in;
   logic [1:0]    slot_m1, slot_m2;
   pos_flags_type pos_flags;

   // input stage
   logic          a_valid_ff;
   pix_type       a_pix_ff;
   logic [XW-1:0] a_cx_ff;
   logic [YW-1:0] a_cy_ff;
   pos_flags_type a_flags_ff;
   logic [1:0]    a_slot_m1_ff, a_slot_m2_ff;
   pix_type       rd_ff [3];
   col_type       cur_col;
   logic          a_adv;

   // window stage
   col_type       p1_ff, p2_ff;
   col_type       b_m2_ff, b_m1_ff, b_c_ff;
   logic [3:0]    b_pend_ff, b_pend_in, pend_new;
   logic [XW-1:0] b_cx_ff;
   logic [YW-1:0] b_cy_ff;
   logic          b_can, out_load;
   logic [1:0]    sel;
   logic [3:0]    sel_oh, rest;
   col_type       cl, cm, cr, ql, qm, qr;
   win_type       win;
   logic [XW-1:0] ox;
   logic [YW-1:0] oy;

   // output register
   logic               rsp_valid_ff;
   pix_type            rsp_median_ff;
   logic [OUT_X_W-1:0] rsp_x_ff;
   logic [OUT_Y_W-1:0] rsp_y_ff;
   logic               rsp_last_ff, rsp_frame_ff;

   // ---------------- configuration ----------------
   assign csr_if.ready = 1'b1;
   assign csr_fire     = csr_if.valid;

   // zero is taken as one, anything above the maximum saturates
   assign w_wr = WCW'(csr_if.wdata[CSR_WIDTH_W-1:0]);
   assign h_wr = HCW'(csr_if.wdata[CSR_HEIGHT_W-1:0]);
   assign w_last_wr = (w_wr == '0) ? '0 :
                      (w_wr > WCW'(MAX_WIDTH)) ? XW'(MAX_WIDTH - 1) : XW'(w_wr - WCW'(1));
   assign h_last_wr = (h_wr == '0) ? '0 :
                      (h_wr > HCW'(MAX_HEIGHT)) ? YW'(MAX_HEIGHT - 1) : YW'(h_wr - HCW'(1));

   always_comb begin
      w_last_in = w_last_ff;
      h_last_in = h_last_ff;
      csr_hit   = 1'b0;
      if (csr_fire) begin
         case (csr_if.addr)
            CSR_IMAGE_WIDTH: begin
               w_last_in = w_last_wr;
               csr_hit   = 1'b1;
            end
            CSR_IMAGE_HEIGHT: begin
               h_last_in = h_last_wr;
               csr_hit   = 1'b1;
            end
            default: csr_hit = 1'b0;
         endcase
      end
   end

   // ---------------- position counters ----------------
   assign req_if.ready = !a_valid_ff || b_can;
   assign req_fire     = req_if.valid && req_if.ready;

   always_comb begin
      cx_in   = cx_ff;
      cy_in   = cy_ff;
      slot_in = slot_ff;
      if (csr_hit) begin
         // a write to the width or height register restarts the frame
         cx_in   = '0;
         cy_in   = '0;
         slot_in = '0;
      end else if (req_fire) begin
         if (cx_ff == w_last_ff) begin
            cx_in = '0;
            if (cy_ff == h_last_ff) begin
               cy_in   = '0;
               slot_in = '0;
            end else begin
               cy_in   = cy_ff + YW'(1);
               slot_in = (slot_ff == 2'd2) ? 2'd0 : slot_ff + 2'd1;
            end
         end else begin
            cx_in = cx_ff + XW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         w_last_ff <= W_LAST_RST;
         h_last_ff <= H_LAST_RST;
         cx_ff     <= '0;
         cy_ff     <= '0;
         slot_ff   <= '0;
      end else begin
         w_last_ff <= w_last_in;
         h_last_ff <= h_last_in;
         cx_ff     <= cx_in;
         cy_ff     <= cy_in;
         slot_ff   <= slot_in;
      end
   end

   // buffers of the rows one and two above the current one
   assign slot_m1 = (slot_ff == 2'd0) ? 2'd2 : slot_ff - 2'd1;
   assign slot_m2 = (slot_ff == 2'd2) ? 2'd0 : slot_ff + 2'd1;

   assign pos_flags.xm1 = (cx_ff != '0);
   assign pos_flags.xm2 = (cx_ff > XW'(1));
   assign pos_flags.xe  = (cx_ff == w_last_ff);
   assign pos_flags.ym1 = (cy_ff != '0);
   assign pos_flags.ym2 = (cy_ff > YW'(1));
   assign pos_flags.ye  = (cy_ff == h_last_ff);

   // ---------------- row buffers ----------------
   for (genvar g = 0; g < 3; g++) begin : g_row
      pix_type row_mem [MAX_WIDTH];

      always_ff @(posedge clock) begin
         if (req_fire) begin
            if (slot_ff == 2'(g)) begin
               row_mem[cx_ff] <= req_if.pixel;
            end
            rd_ff[g] <= row_mem[cx_ff];
         end
      end
   end

   // ---------------- input stage ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else if (req_fire) begin
         a_valid_ff <= 1'b1;
      end else if (a_adv) begin
         a_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         a_pix_ff     <= req_if.pixel;
         a_cx_ff      <= cx_ff;
         a_cy_ff      <= cy_ff;
         a_flags_ff   <= pos_flags;
         a_slot_m1_ff <= slot_m1;
         a_slot_m2_ff <= slot_m2;
      end
   end

   // vertical clamp: missing rows above repeat the nearest one
   assign cur_col.r2 = a_pix_ff;
   assign cur_col.r1 = a_flags_ff.ym1 ? rd_ff[a_slot_m1_ff] : a_pix_ff;
   assign cur_col.r0 = a_flags_ff.ym2 ? rd_ff[a_slot_m2_ff] : cur_col.r1;

   assign pend_new = {a_flags_ff.ye & a_flags_ff.xe, a_flags_ff.ye & a_flags_ff.xm1,
                      a_flags_ff.ym1 & a_flags_ff.xe, a_flags_ff.ym1 & a_flags_ff.xm1};

   assign a_adv = a_valid_ff && b_can;

   // ---------------- window stage ----------------
   always_comb begin
      if (b_pend_ff[0]) begin
         sel = 2'd0;
      end else if (b_pend_ff[1]) begin
         sel = 2'd1;
      end else if (b_pend_ff[2]) begin
         sel = 2'd2;
      end else begin
         sel = 2'd3;
      end
   end

   assign sel_oh   = 4'b0001 << sel;
   assign rest     = b_pend_ff & ~sel_oh;
   assign out_load = (b_pend_ff != '0) && (!rsp_valid_ff || rsp_if.ready);
   assign b_can    = (b_pend_ff == '0) || (out_load && (rest == '0));

   always_comb begin
      b_pend_in = b_pend_ff;
      if (a_adv) begin
         b_pend_in = pend_new;
      end else if (out_load) begin
         b_pend_in = rest;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b_pend_ff <= '0;
      end else begin
         b_pend_ff <= b_pend_in;
      end
   end

   // horizontal clamp happens here: columns left of the row start repeat the nearest one
   always_ff @(posedge clock) begin
      if (a_adv) begin
         p1_ff   <= cur_col;
         p2_ff   <= p1_ff;
         b_m2_ff <= a_flags_ff.xm2 ? p2_ff : p1_ff;
         b_m1_ff <= a_flags_ff.xm1 ? p1_ff : cur_col;
         b_c_ff  <= cur_col;
         b_cx_ff <= a_cx_ff;
         b_cy_ff <= a_cy_ff;
      end
   end

   // sel[0]: centre column is the current one, sel[1]: centre row is the current one
   assign cl = sel[0] ? b_m1_ff : b_m2_ff;
   assign cm = sel[0] ? b_c_ff  : b_m1_ff;
   assign cr = b_c_ff;

   assign ql = sel[1] ? col_type'{r0: cl.r1, r1: cl.r2, r2: cl.r2} : cl;
   assign qm = sel[1] ? col_type'{r0: cm.r1, r1: cm.r2, r2: cm.r2} : cm;
   assign qr = sel[1] ? col_type'{r0: cr.r1, r1: cr.r2, r2: cr.r2} : cr;

   assign win = {qr.r2, qm.r2, ql.r2, qr.r1, qm.r1, ql.r1, qr.r0, qm.r0, ql.r0};

   assign ox = sel[0] ? b_cx_ff : b_cx_ff - XW'(1);
   assign oy = sel[1] ? b_cy_ff : b_cy_ff - YW'(1);

   // ---------------- output register ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_if.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         rsp_median_ff <= median9(win);
         rsp_x_ff      <= OUT_X_W'(ox);
         rsp_y_ff      <= OUT_Y_W'(oy);
         rsp_last_ff   <= (rest == '0);
         rsp_frame_ff  <= (sel == 2'd3);
      end
   end

   assign rsp_if.valid       = rsp_valid_ff;
   assign rsp_if.median      = rsp_median_ff;
   assign rsp_if.out_x       = rsp_x_ff;
   assign rsp_if.out_y       = rsp_y_ff;
   assign rsp_if.last_of_run = rsp_last_ff;
   assign rsp_if.frame_done  = rsp_frame_ff;

   // ---------------- assertions ----------------
   a_pos_in_frame: assert property (@(posedge clock) disable iff (reset)
      (cx_ff <= w_last_ff) && (cy_ff <= h_last_ff))
      else $error("position counter outside the frame");

   a_slot_range: assert property (@(posedge clock) disable iff (reset)
      slot_ff != 2'd3)
      else $error("row buffer slot out of range");

   a_frame_wrap: assert property (@(posedge clock) disable iff (reset)
      req_fire && (cx_ff == w_last_ff) && (cy_ff == h_last_ff)
      |=> (cx_ff == '0) && (cy_ff == '0) && (slot_ff == '0))
      else $error("counters did not wrap at end of frame");

   a_frame_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_frame_ff |-> rsp_last_ff)
      else $error("frame end result is not the last of its run");

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      a_valid_ff && !b_can |=> a_valid_ff && $stable(a_cx_ff) && $stable(a_cy_ff))
      else $error("input stage lost a stalled transaction");

endmodule

`default_nettype wire

>>> tb/tb.sv
// self-checking testbench of the 3x3 median stream filter
`timescale 1ns / 1ps

module tb;
   import med3x3_pkg::*;

   localparam int MAX_COLS         = 1024;
   localparam int MAX_ROWS         = 4096;
   localparam int TOTAL_PIXELS     = 320;
   localparam int SETTLE_CYCLES    = 8;
   localparam int TAIL_CYCLES      = 20;
   localparam int LONG_HOLD_CYCLES = 90;
   localparam int MAX_REPORTS      = 200;
   localparam int DIR_ROWS         = 33;
   localparam longint TIMEOUT_NS   = 2_000_000;

   localparam logic [CSR_ADDR_W-1:0] CSR_SPARE_TOP   = '1;
   localparam int                    FIRST_SPARE_IDX = 2;

   typedef enum logic {ROW_CSR, ROW_PIX} row_kind_type;

   // echo rows run at 1x1, so the result is the pixel itself at (0,0)
   typedef struct {
      row_kind_type          kind;
      logic [CSR_ADDR_W-1:0] idx;
      logic [CSR_DATA_W-1:0] value;
      pix_type               pixel;
      bit                    echo;
   } stim_row_type;

   typedef struct packed {
      pix_type             median;
      logic [OUT_X_W-1:0]  x;
      logic [OUT_Y_W-1:0]  y;
      logic                last_of_run;
      logic                frame_done;
   } filtered_px_type;

   logic clock = 1'b0;
   logic reset;

   med3x3_csr_if csr_bus ();
   med3x3_pix_if pix_bus ();
   med3x3_res_if res_bus ();

   median3x3_stream_filter u_dut (
      .clock  (clock),
      .reset  (reset),
      .csr_if (csr_bus),
      .req_if (pix_bus),
      .rsp_if (res_bus)
   );

   always #2 clock = ~clock;

   // predictor state
   pix_type                 line_mem [0:3*MAX_COLS-1];
   int unsigned             col_pos;
   int unsigned             row_pos;
   logic [CSR_WIDTH_W-1:0]  width_reg;
   logic [CSR_HEIGHT_W-1:0] height_reg;

   filtered_px_type pending_medians [$];
   int              errors;
   int              pix_count;
   int              long_holds_asked;
   int              long_holds_served;

   stim_row_type directed_rows [DIR_ROWS] = '{
      '{ROW_CSR, CSR_IMAGE_WIDTH,  16'd1,    8'h00, 1'b0},
      '{ROW_CSR, CSR_IMAGE_HEIGHT, 16'd1,    8'h00, 1'b0},
      '{ROW_PIX, CSR_IMAGE_WIDTH,  16'd0,    8'h00, 1'b1},
      '{ROW_PIX, CSR_IMAGE_WIDTH,  16'd0,    8'hFF, 1'b1},
      '{ROW_PIX, CSR_IMAGE_WIDTH,  16'd0,    8'hA5, 1'b1},
      '{ROW_CSR, CSR_IMAGE_WIDTH,  16'd0,    8'h00, 1'b0},
      '{ROW_CSR, CSR_IMAGE_HEIGHT, 16'd0,    8'h00, 1'b0},
      '{ROW_PIX, CSR_IMAGE_WIDTH,  16'd0,    8'h5A, 1'b1},
      '{ROW_CSR, CSR_SPARE_TOP,    16'hFFFF, 8'h00, 1'b0},
      '{ROW_PIX, CSR_IMAGE_WIDTH,  16'd0,    8'h01, 1'b1},
      '{ROW_CSR, CSR_IMAGE_WIDTH,  16'd3,    8'h00, 1'b0},
      '{ROW_CSR, CSR_IMAGE_HEIGHT, 16'd3,    8'h00, 1'b0},
      '{ROW_PIX, CSR_IMAGE_WIDTH,  16'd0,    8'hFF, 1'b0},
      '{ROW_PIX, CSR_IMAGE_WIDTH,  16'd0,    8'h00, 1'b0},
      '{ROW_PIX, CSR_IMAGE_WIDTH,  16'd0,    8'hFF, 1'b0},
      '{ROW_PIX, CSR_IMAGE_WIDTH,  16'd0,    8'h00, 1'b0},
      '{ROW_PIX, CSR_IMAGE_WIDTH,  16'd0,    8'hFF, 1'b0},
      '{ROW_PIX, CSR_IMAGE_WIDTH,  16'd0,    8'h00, 1'b0},
      '{ROW_PIX, CSR_IMAGE_WIDTH,  16'd0,    8'hFF, 1'b0},
      '{ROW_PIX, CSR_IMAGE_WIDTH,  16'd0,    8'h00, 1'b0},
      '{ROW_PIX, CSR_IMAGE_WIDTH,  16'd0,    8'hFF, 1'b0},
      '{ROW_CSR, CSR_IMAGE_WIDTH,  16'hFFFF, 8'h00, 1'b0},
      '{ROW_CSR, CSR_IMAGE_HEIGHT, 16'd1,    8'h00, 1'b0},
      '{ROW_PIX, CSR_IMAGE_WIDTH,  16'd0,    8'h80, 1'b0},
      '{ROW_PIX, CSR_IMAGE_WIDTH,  16'd0,    8'h7F, 1'b0},
      '{ROW_PIX, CSR_IMAGE_WIDTH,  16'd0,    8'hFE, 1'b0},
      '{ROW_PIX, CSR_IMAGE_WIDTH,  16'd0,    8'h02, 1'b0},
      '{ROW_CSR, CSR_IMAGE_WIDTH,  16'h0800, 8'h00, 1'b0},
      '{ROW_CSR, CSR_IMAGE_HEIGHT, 16'hFFFF, 8'h00, 1'b0},
      '{ROW_PIX, CSR_IMAGE_WIDTH,  16'd0,    8'h10, 1'b0},
      '{ROW_PIX, CSR_IMAGE_WIDTH,  16'd0,    8'h20, 1'b0},
      '{ROW_PIX, CSR_IMAGE_WIDTH,  16'd0,    8'h30, 1'b0},
      '{ROW_PIX, CSR_IMAGE_WIDTH,  16'd0,    8'h40, 1'b0}
   };

   function automatic int unsigned active_width();
      int unsigned w;
      w = width_reg;
      if (w == 0) w = 1;
      if (w > MAX_COLS) w = MAX_COLS;
      return w;
   endfunction

   function automatic int unsigned active_height();
      int unsigned h;
      h = height_reg;
      if (h == 0) h = 1;
      if (h > MAX_ROWS) h = MAX_ROWS;
      return h;
   endfunction

   function automatic void apply_csr(logic [CSR_ADDR_W-1:0] idx, logic [CSR_DATA_W-1:0] val);
      if (idx == CSR_IMAGE_WIDTH) begin
         width_reg = val[CSR_WIDTH_W-1:0];
         col_pos   = 0;
         row_pos   = 0;
      end else if (idx == CSR_IMAGE_HEIGHT) begin
         height_reg = val[CSR_HEIGHT_W-1:0];
         col_pos    = 0;
         row_pos    = 0;
      end
   endfunction

   // gather the clamped window and pick the middle value of a plain sort
   function automatic pix_type median_at(int unsigned x, int unsigned y,
                                         int unsigned w, int unsigned h);
      pix_type vals [9];
      pix_type t;
      int      j, k, ry, rx;
      k = 0;
      for (int dy = -1; dy <= 1; dy++) begin
         ry = int'(y) + dy;
         if (ry < 0) ry = 0;
         if (ry > int'(h) - 1) ry = int'(h) - 1;
         for (int dx = -1; dx <= 1; dx++) begin
            rx = int'(x) + dx;
            if (rx < 0) rx = 0;
            if (rx > int'(w) - 1) rx = int'(w) - 1;
            vals[k] = line_mem[(ry % 3) * MAX_COLS + rx];
            k++;
         end
      end
      for (int i = 1; i < 9; i++) begin
         t = vals[i];
         j = i - 1;
         while (j >= 0 && vals[j] > t) begin
            vals[j+1] = vals[j];
            j--;
         end
         vals[j+1] = t;
      end
      return vals[4];
   endfunction

   // store the pixel and queue every neighbourhood that it completes
   function automatic void absorb_pixel(pix_type p);
      int unsigned     w, h, cx, cy;
      int unsigned     xs [2];
      int unsigned     ys [2];
      int              nx, ny;
      filtered_px_type batch [$];
      filtered_px_type r;
      w  = active_width();
      h  = active_height();
      cx = col_pos;
      cy = row_pos;
      if (cx >= w) cx = 0;
      if (cy >= h) cy = 0;
      line_mem[(cy % 3) * MAX_COLS + cx] = p;
      nx = 0;
      ny = 0;
      if (cx >= 1) begin
         xs[nx] = cx - 1;
         nx++;
      end
      if (cx == w - 1) begin
         xs[nx] = cx;
         nx++;
      end
      if (cy >= 1) begin
         ys[ny] = cy - 1;
         ny++;
      end
      if (cy == h - 1) begin
         ys[ny] = cy;
         ny++;
      end
      for (int j = 0; j < ny; j++) begin
         for (int i = 0; i < nx; i++) begin
            r.median      = median_at(xs[i], ys[j], w, h);
            r.x           = OUT_X_W'(xs[i]);
            r.y           = OUT_Y_W'(ys[j]);
            r.last_of_run = 1'b0;
            r.frame_done  = (xs[i] == w - 1) && (ys[j] == h - 1);
            batch.push_back(r);
         end
      end
      if (batch.size() != 0) batch[batch.size()-1].last_of_run = 1'b1;
      foreach (batch[i]) pending_medians.push_back(batch[i]);
      cx++;
      if (cx >= w) begin
         cx = 0;
         cy++;
         if (cy >= h) cy = 0;
      end
      col_pos = cx;
      row_pos = cy;
   endfunction

   // mostly short gaps, now and then a long one
   function automatic int unsigned idle_len();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 10);
      return $urandom_range(20, 40);
   endfunction

   function automatic pix_type random_pixel();
      int unsigned r;
      r = $urandom_range(0, 9);
      if (r == 0) return '0;
      if (r == 1) return '1;
      return pix_type'($urandom_range(0, 255));
   endfunction

   task automatic send_pixel(pix_type p, bit echo, int unsigned gap);
      filtered_px_type known;
      pix_bus.valid <= 1'b1;
      pix_bus.pixel <= p;
      do @(posedge clock); while (pix_bus.ready !== 1'b1);
      absorb_pixel(p);
      if (echo) begin
         known = '{median: p, x: '0, y: '0, last_of_run: 1'b1, frame_done: 1'b1};
         void'(pending_medians.pop_back());
         pending_medians.push_back(known);
      end
      pix_count++;
      if (gap != 0) begin
         pix_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // registers change only once the filter has gone quiet
   task automatic write_reg(logic [CSR_ADDR_W-1:0] idx, logic [CSR_DATA_W-1:0] val);
      pix_bus.valid <= 1'b0;
      while (pending_medians.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_bus.valid <= 1'b1;
      csr_bus.addr  <= idx;
      csr_bus.wdata <= val;
      do @(posedge clock); while (csr_bus.ready !== 1'b1);
      apply_csr(idx, val);
      csr_bus.valid <= 1'b0;
   endtask

   // result side: random back-pressure with calm stretches and the odd long hold
   initial begin
      int unsigned stall_left;
      int unsigned stretch_left;
      bit          calm;
      stall_left   = 0;
      stretch_left = 0;
      calm         = 1'b0;
      res_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (stretch_left == 0) begin
            stretch_left = $urandom_range(40, 160);
            calm         = ($urandom_range(0, 2) == 0);
         end
         stretch_left--;
         if (long_holds_served != long_holds_asked) begin
            long_holds_served++;
            res_bus.ready <= 1'b0;
            repeat (LONG_HOLD_CYCLES) @(posedge clock);
            res_bus.ready <= 1'b1;
         end else if (stall_left != 0) begin
            res_bus.ready <= 1'b0;
            stall_left--;
         end else begin
            res_bus.ready <= 1'b1;
            if (!calm && $urandom_range(0, 5) == 0) stall_left = idle_len();
         end
      end
   end

   // result checker
   always @(posedge clock) begin
      filtered_px_type want;
      if (!reset && res_bus.valid === 1'b1 && res_bus.ready === 1'b1) begin
         if (pending_medians.size() == 0) begin
            errors++;
            if (errors <= MAX_REPORTS)
               $display("%0t: unexpected result median=%0d x=%0d y=%0d last=%0b done=%0b",
                        $time, res_bus.median, res_bus.out_x, res_bus.out_y,
                        res_bus.last_of_run, res_bus.frame_done);
         end else begin
            want = pending_medians.pop_front();
            if (res_bus.median !== want.median || res_bus.out_x !== want.x ||
                res_bus.out_y !== want.y || res_bus.last_of_run !== want.last_of_run ||
                res_bus.frame_done !== want.frame_done) begin
               errors++;
               if (errors <= MAX_REPORTS)
                  $display("%0t: mismatch expected median=%0d x=%0d y=%0d last=%0b done=%0b, %s",
                           $time, want.median, want.x, want.y, want.last_of_run,
                           want.frame_done,
                           $sformatf("actual median=%0d x=%0d y=%0d last=%0b done=%0b",
                                     res_bus.median, res_bus.out_x, res_bus.out_y,
                                     res_bus.last_of_run, res_bus.frame_done));
            end
         end
      end
   end

   initial begin
      #(TIMEOUT_NS);
      $display("Regression FAIL");
      $finish;
   end

   initial begin
      int          phase;
      int unsigned kind, w, h, span, count, pick;
      bit          steady_feed;
      errors            = 0;
      pix_count         = 0;
      long_holds_asked  = 0;
      long_holds_served = 0;
      col_pos           = 0;
      row_pos           = 0;
      width_reg         = CSR_WIDTH_W'(IMG_WIDTH_RST);
      height_reg        = CSR_HEIGHT_W'(IMG_HEIGHT_RST);
      reset         <= 1'b1;
      csr_bus.valid <= 1'b0;
      csr_bus.addr  <= '0;
      csr_bus.wdata <= '0;
      pix_bus.valid <= 1'b0;
      pix_bus.pixel <= '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_rows[i]) begin
         if (directed_rows[i].kind == ROW_CSR)
            write_reg(directed_rows[i].idx, directed_rows[i].value);
         else
            send_pixel(directed_rows[i].pixel, directed_rows[i].echo, idle_len());
      end

      phase = 0;
      while (pix_count < TOTAL_PIXELS) begin
         kind        = $urandom_range(0, 15);
         steady_feed = ($urandom_range(0, 3) == 0);
         if (phase == 2) begin
            // block fills up behind a long result hold
            write_reg(CSR_IMAGE_WIDTH, 16'd4);
            write_reg(CSR_IMAGE_HEIGHT, 16'd5);
            count       = 60;
            steady_feed = 1'b1;
            long_holds_asked++;
         end else if (kind == 0) begin
            // widest rows, single-row frame
            if ($urandom_range(0, 1) == 0)
               write_reg(CSR_IMAGE_WIDTH, CSR_DATA_W'(MAX_COLS));
            else
               write_reg(CSR_IMAGE_WIDTH, {5'($urandom), 11'h7FF});
            write_reg(CSR_IMAGE_HEIGHT, {3'($urandom), 13'd1});
            count = $urandom_range(20, 40);
         end else if (kind == 1) begin
            // tallest frame, one pixel per row
            write_reg(CSR_IMAGE_WIDTH, 16'd1);
            if ($urandom_range(0, 1) == 0)
               write_reg(CSR_IMAGE_HEIGHT, CSR_DATA_W'(MAX_ROWS));
            else
               write_reg(CSR_IMAGE_HEIGHT, {3'($urandom), 13'h1FFF});
            count = $urandom_range(20, 40);
         end else if (kind == 2) begin
            // spare index: frame carries on untouched
            write_reg(CSR_ADDR_W'($urandom_range(FIRST_SPARE_IDX, 15)),
                      CSR_DATA_W'($urandom));
            count = $urandom_range(1, 20);
         end else begin
            w    = $urandom_range(0, 9);
            h    = $urandom_range(0, 6);
            pick = $urandom_range(0, 3);
            if (pick != 1) begin
               if ($urandom_range(0, 3) == 0)
                  write_reg(CSR_IMAGE_WIDTH, {5'($urandom), 11'(w)});
               else
                  write_reg(CSR_IMAGE_WIDTH, CSR_DATA_W'(w));
            end
            if (pick != 0) begin
               if ($urandom_range(0, 3) == 0)
                  write_reg(CSR_IMAGE_HEIGHT, {3'($urandom), 13'(h)});
               else
                  write_reg(CSR_IMAGE_HEIGHT, CSR_DATA_W'(h));
            end
            span  = active_width() * active_height();
            count = $urandom_range(1, 2) * span;
            if ($urandom_range(0, 2) == 0) count += $urandom_range(1, span);
            if (count > 120) count = 120;
         end
         // keep the whole run near the planned number of pixels
         if (count > int'(TOTAL_PIXELS - pix_count))
            count = int'(TOTAL_PIXELS - pix_count);
         for (int n = 0; n < int'(count); n++) begin
            send_pixel(random_pixel(), 1'b0, steady_feed ? 0 : idle_len());
            if ($urandom_range(0, 39) == 0) begin
               // let the filter run dry mid-frame
               pix_bus.valid <= 1'b0;
               @(posedge clock);
               while (pending_medians.size() != 0) @(posedge clock);
            end
         end
         phase++;
      end

      pix_bus.valid <= 1'b0;
      @(posedge clock);
      while (pending_medians.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
      if (errors == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule
